[src/affa_pkg.sv]
// Shared types and constants of the aligned first-fit allocator.
package affa_pkg;

  localparam int PosBits = 9;

  typedef enum logic [1:0] {
    STAT_OK       = 2'd0,
    STAT_NOFIT    = 2'd1,
    STAT_FULL     = 2'd2,
    STAT_NOTALLOC = 2'd3
  } status_e;

  typedef enum logic [0:0] {
    KIND_ALLOC = 1'b0,
    KIND_FREE  = 1'b1
  } kind_e;

  typedef enum logic [1:0] {
    OP_NOP    = 2'd0,
    OP_WRITE  = 2'd1,
    OP_DELETE = 2'd2,
    OP_INSERT = 2'd3
  } cell_op_e;

  typedef enum logic [3:0] {
    S_IDLE,
    S_A_SCAN,
    S_A_FWR,
    S_A_FINS,
    S_U_SCAN,
    S_F_USCAN,
    S_F_FSCAN,
    S_F_UPD,
    S_F_FDEL,
    S_DONE
  } state_e;

  typedef struct packed {
    cell_op_e             op;
    logic [PosBits-1:0]   pos;
  } cell_cmd_t;

  typedef struct packed {
    logic        kind;
    logic [16:0] req_bytes;
    logic [15:0] block_offset;
  } req_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [15:0] offset;
    logic [16:0] block_size;
  } rsp_t;

endpackage

[src/affa_cell.sv]
// One table entry: holds an offset and a size, shifts with its neighbors.
module affa_cell import affa_pkg::*; #(
  parameter int DW       = 18,
  parameter int K        = 0,
  parameter int RST_SIZE = 0
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  cell_cmd_t     cmd_i,
  input  logic [DW-1:0] wr_off_i,
  input  logic [DW-1:0] wr_size_i,
  input  logic [DW-1:0] left_off_i,
  input  logic [DW-1:0] left_size_i,
  input  logic [DW-1:0] right_off_i,
  input  logic [DW-1:0] right_size_i,
  output logic [DW-1:0] off_o,
  output logic [DW-1:0] size_o
);

  logic [DW-1:0] off_q, off_d, size_q, size_d;
  logic [PosBits-1:0] k_pos;

  assign k_pos = PosBits'(K);

  always_comb begin
    off_d  = off_q;
    size_d = size_q;
    unique case (cmd_i.op)
      OP_WRITE: begin
        if (k_pos == cmd_i.pos) begin
          off_d  = wr_off_i;
          size_d = wr_size_i;
        end
      end
      OP_DELETE: begin
        // close the gap: take the right neighbor
        if (k_pos >= cmd_i.pos) begin
          off_d  = right_off_i;
          size_d = right_size_i;
        end
      end
      OP_INSERT: begin
        if (k_pos == cmd_i.pos) begin
          off_d  = wr_off_i;
          size_d = wr_size_i;
        end else if (k_pos > cmd_i.pos) begin
          off_d  = left_off_i;
          size_d = left_size_i;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      off_q  <= '0;
      size_q <= DW'(RST_SIZE);
    end else begin
      off_q  <= off_d;
      size_q <= size_d;
    end
  end

  assign off_o  = off_q;
  assign size_o = size_q;

endmodule

[src/affa_chain.sv]
// Sorted table built as a row of entry cells with one read port.
module affa_chain import affa_pkg::*; #(
  parameter int DW        = 18,
  parameter int DEPTH     = 16,
  parameter int INIT_SIZE = 0
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  cell_cmd_t          cmd_i,
  input  logic [DW-1:0]      wr_off_i,
  input  logic [DW-1:0]      wr_size_i,
  input  logic [PosBits-1:0] rd_pos_i,
  output logic [DW-1:0]      rd_off_o,
  output logic [DW-1:0]      rd_size_o
);

  localparam int IW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  logic [DW-1:0] offs [DEPTH+2];
  logic [DW-1:0] sizes[DEPTH+2];

  // offs[k+1] belongs to cell k; both ends are tied to zero
  assign offs[0]        = '0;
  assign sizes[0]       = '0;
  assign offs[DEPTH+1]  = '0;
  assign sizes[DEPTH+1] = '0;

  for (genvar k = 0; k < DEPTH; k++) begin : g_cell
    affa_cell #(
      .DW       (DW),
      .K        (k),
      .RST_SIZE ((k == 0) ? INIT_SIZE : 0)
    ) u_cell (
      .clk_i        (clk_i),
      .rst_ni       (rst_ni),
      .cmd_i        (cmd_i),
      .wr_off_i     (wr_off_i),
      .wr_size_i    (wr_size_i),
      .left_off_i   (offs[k]),
      .left_size_i  (sizes[k]),
      .right_off_i  (offs[k+2]),
      .right_size_i (sizes[k+2]),
      .off_o        (offs[k+1]),
      .size_o       (sizes[k+1])
    );
  end

  logic [IW-1:0] idx;
  logic [DW-1:0] sel_off [DEPTH];
  logic [DW-1:0] sel_size[DEPTH];

  for (genvar k = 0; k < DEPTH; k++) begin : g_sel
    assign sel_off[k]  = offs[k+1];
    assign sel_size[k] = sizes[k+1];
  end

  assign idx = rd_pos_i[IW-1:0];

  always_comb begin
    if (rd_pos_i < PosBits'(DEPTH)) begin
      rd_off_o  = sel_off[idx];
      rd_size_o = sel_size[idx];
    end else begin
      rd_off_o  = '0;
      rd_size_o = '0;
    end
  end

endmodule

[src/aligned_first_fit_allocator_top.sv]
// Top level of the aligned first-fit pool allocator with coalescing.
//
// The allocator manages a pool of pool_size bytes through two offset-sorted
// tables, a free table and a used table, each a row of entry cells that
// shift in place to insert or delete an entry. An allocate request rounds
// its size (1..8 to 1,2,4,4,8,8,8,8 with equal alignment, anything else up
// to a multiple of 16, at least 16, with 16-byte alignment), scans the free
// table one entry a cycle for the first aligned fit, updates the free table
// in S_A_FWR and, when the fit splits the entry in two, in S_A_FINS, and
// then scans the used table one entry a cycle to insert the new block. A
// free request scans the used table for the offset, scans the free table
// for the merge point and then updates both tables in S_F_UPD and, when the
// block merges on both sides, in S_F_FDEL. Each table has a single-entry
// read port, so every scan reads one entry at a time. One request is in
// work at a time; a finished response waits in the output register while
// the next request is taken. Writing pool_size (saturated to
// 2^POOL_ADDR_BITS) resets both tables at once; write it only while the
// block is idle.
module aligned_first_fit_allocator_top import affa_pkg::*; #(
  parameter int MAX_FREE       = 16,
  parameter int MAX_USED       = 16,
  parameter int POOL_ADDR_BITS = 16
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid,
  output logic        in_stall,
  input  req_t        in_data_i,
  output logic        out_valid,
  input  logic        out_stall,
  output rsp_t        out_data_o,
  input  logic        cfg_we,
  input  logic [16:0] cfg_wdata
);

  // internal width for offsets, sizes and their sums
  localparam int DW  = ((POOL_ADDR_BITS > 16) ? POOL_ADDR_BITS : 16) + 2;
  localparam int FCW = $clog2(MAX_FREE + 1);
  localparam int UCW = $clog2(MAX_USED + 1);

  state_e state_q, state_d;

  logic [FCW-1:0] fcnt_q, fcnt_d, fi_q, fi_d;
  logic [UCW-1:0] ucnt_q, ucnt_d, ui_q, ui_d;
  logic [DW-1:0]  rsz_q, rsz_d, amask_q, amask_d;
  logic [DW-1:0]  s_q, s_d, off_q, off_d, lead_q, lead_d, trail_q, trail_d;
  logic           has_lead_q, has_lead_d, has_trail_q, has_trail_d;
  logic [DW-1:0]  sz_q, sz_d, prev_off_q, prev_off_d, prev_sz_q, prev_sz_d;
  logic [DW-1:0]  nsz_q, nsz_d;
  logic           mprev_q, mprev_d, mnext_q, mnext_d;
  rsp_t           res_q, res_d, out_q, out_d;
  logic           out_valid_q, out_valid_d;

  cell_cmd_t      f_cmd, u_cmd;
  logic [DW-1:0]  f_wr_off, f_wr_size, u_wr_off, u_wr_size;
  logic [PosBits-1:0] f_rd_pos, u_rd_pos;
  logic [DW-1:0]  f_off, f_sz, u_off, u_sz;

  // per-entry fit arithmetic for the allocate scan
  logic [DW-1:0]  s_w, end_w, lead_w, trail_w, pool_w, limit_w, req_w, r_w;
  logic           fit_w;
  logic [FCW:0]   need_w;
  logic           mprev_w, mnext_w;

  affa_chain #(
    .DW        (DW),
    .DEPTH     (MAX_FREE),
    .INIT_SIZE (65536)
  ) u_free (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .cmd_i     (f_cmd),
    .wr_off_i  (f_wr_off),
    .wr_size_i (f_wr_size),
    .rd_pos_i  (f_rd_pos),
    .rd_off_o  (f_off),
    .rd_size_o (f_sz)
  );

  affa_chain #(
    .DW        (DW),
    .DEPTH     (MAX_USED),
    .INIT_SIZE (0)
  ) u_used (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .cmd_i     (u_cmd),
    .wr_off_i  (u_wr_off),
    .wr_size_i (u_wr_size),
    .rd_pos_i  (u_rd_pos),
    .rd_off_o  (u_off),
    .rd_size_o (u_sz)
  );

  assign f_rd_pos = PosBits'(fi_q);
  assign u_rd_pos = PosBits'(ui_q);

  assign s_w     = (f_off + amask_q) & ~amask_q;
  assign end_w   = f_off + f_sz;
  assign fit_w   = (s_w + rsz_q) <= end_w;
  assign lead_w  = s_w - f_off;
  assign trail_w = end_w - s_w - rsz_q;
  assign need_w  = (FCW+1)'(fcnt_q) + (FCW+1)'(lead_w != '0) + (FCW+1)'(trail_w != '0);

  assign limit_w = DW'(1) << POOL_ADDR_BITS;
  assign pool_w  = (DW'(cfg_wdata) > limit_w) ? limit_w : DW'(cfg_wdata);
  assign req_w   = DW'(in_data_i.req_bytes);
  assign r_w     = (req_w + DW'(15)) & ~DW'(15);

  assign mnext_w = (FCW'(fi_q) < fcnt_q) && ((off_q + sz_q) == f_off);
  assign mprev_w = (fi_q != '0) && ((prev_off_q + prev_sz_q) == off_q);

  always_comb begin
    state_d     = state_q;
    fcnt_d      = fcnt_q;
    ucnt_d      = ucnt_q;
    fi_d        = fi_q;
    ui_d        = ui_q;
    rsz_d       = rsz_q;
    amask_d     = amask_q;
    s_d         = s_q;
    off_d       = off_q;
    lead_d      = lead_q;
    trail_d     = trail_q;
    has_lead_d  = has_lead_q;
    has_trail_d = has_trail_q;
    sz_d        = sz_q;
    prev_off_d  = prev_off_q;
    prev_sz_d   = prev_sz_q;
    nsz_d       = nsz_q;
    mprev_d     = mprev_q;
    mnext_d     = mnext_q;
    res_d       = res_q;
    out_d       = out_q;
    out_valid_d = out_valid_q;
    f_cmd       = '{op: OP_NOP, pos: '0};
    u_cmd       = '{op: OP_NOP, pos: '0};
    f_wr_off    = '0;
    f_wr_size   = '0;
    u_wr_off    = '0;
    u_wr_size   = '0;
    in_stall    = (state_q != S_IDLE);

    // drop the response once the consumer takes it
    if (out_valid_q && !out_stall) begin
      out_valid_d = 1'b0;
    end

    unique case (state_q)
      S_IDLE: begin
        if (in_valid) begin
          fi_d = '0;
          ui_d = '0;
          if (in_data_i.kind == KIND_FREE) begin
            off_d   = DW'(in_data_i.block_offset);
            state_d = S_F_USCAN;
          end else begin
            priority case (in_data_i.req_bytes)
              17'd1: begin rsz_d = DW'(1); amask_d = DW'(0); end
              17'd2: begin rsz_d = DW'(2); amask_d = DW'(1); end
              17'd3, 17'd4: begin rsz_d = DW'(4); amask_d = DW'(3); end
              17'd5, 17'd6, 17'd7, 17'd8: begin rsz_d = DW'(8); amask_d = DW'(7); end
              default: begin
                rsz_d   = (r_w == '0) ? DW'(16) : r_w;
                amask_d = DW'(15);
              end
            endcase
            state_d = S_A_SCAN;
          end
        end
      end

      S_A_SCAN: begin
        if (fi_q >= fcnt_q) begin
          res_d   = '{status: STAT_NOFIT, offset: '0, block_size: '0};
          state_d = S_DONE;
        end else if (fit_w) begin
          if ((UCW'(MAX_USED) <= ucnt_q) || (need_w > (FCW+1)'(MAX_FREE + 1))) begin
            res_d   = '{status: STAT_FULL, offset: '0, block_size: '0};
            state_d = S_DONE;
          end else begin
            s_d         = s_w;
            off_d       = f_off;
            lead_d      = lead_w;
            trail_d     = trail_w;
            has_lead_d  = (lead_w != '0);
            has_trail_d = (trail_w != '0);
            state_d     = S_A_FWR;
          end
        end else begin
          fi_d = fi_q + FCW'(1);
        end
      end

      S_A_FWR: begin
        ui_d    = '0;
        state_d = S_U_SCAN;
        priority if (!has_lead_q && !has_trail_q) begin
          f_cmd  = '{op: OP_DELETE, pos: PosBits'(fi_q)};
          fcnt_d = fcnt_q - FCW'(1);
        end else if (has_lead_q) begin
          f_cmd     = '{op: OP_WRITE, pos: PosBits'(fi_q)};
          f_wr_off  = off_q;
          f_wr_size = lead_q;
          if (has_trail_q) begin
            state_d = S_A_FINS;
          end
        end else begin
          f_cmd     = '{op: OP_WRITE, pos: PosBits'(fi_q)};
          f_wr_off  = s_q + rsz_q;
          f_wr_size = trail_q;
        end
      end

      S_A_FINS: begin
        f_cmd     = '{op: OP_INSERT, pos: PosBits'(fi_q) + PosBits'(1)};
        f_wr_off  = s_q + rsz_q;
        f_wr_size = trail_q;
        fcnt_d    = fcnt_q + FCW'(1);
        state_d   = S_U_SCAN;
      end

      S_U_SCAN: begin
        if ((ui_q < ucnt_q) && (u_off < s_q)) begin
          ui_d = ui_q + UCW'(1);
        end else begin
          u_cmd     = '{op: OP_INSERT, pos: PosBits'(ui_q)};
          u_wr_off  = s_q;
          u_wr_size = rsz_q;
          ucnt_d    = ucnt_q + UCW'(1);
          res_d     = '{status: STAT_OK, offset: s_q[15:0], block_size: rsz_q[16:0]};
          state_d   = S_DONE;
        end
      end

      S_F_USCAN: begin
        if (ui_q >= ucnt_q) begin
          res_d   = '{status: STAT_NOTALLOC, offset: '0, block_size: '0};
          state_d = S_DONE;
        end else if (u_off == off_q) begin
          sz_d    = u_sz;
          fi_d    = '0;
          state_d = S_F_FSCAN;
        end else begin
          ui_d = ui_q + UCW'(1);
        end
      end

      S_F_FSCAN: begin
        if ((fi_q < fcnt_q) && (f_off < off_q)) begin
          prev_off_d = f_off;
          prev_sz_d  = f_sz;
          fi_d       = fi_q + FCW'(1);
        end else begin
          mnext_d = mnext_w;
          mprev_d = mprev_w;
          nsz_d   = f_sz;
          if (!mprev_w && !mnext_w && (fcnt_q >= FCW'(MAX_FREE))) begin
            res_d   = '{status: STAT_FULL, offset: '0, block_size: '0};
            state_d = S_DONE;
          end else begin
            state_d = S_F_UPD;
          end
        end
      end

      S_F_UPD: begin
        u_cmd   = '{op: OP_DELETE, pos: PosBits'(ui_q)};
        ucnt_d  = ucnt_q - UCW'(1);
        res_d   = '{status: STAT_OK, offset: off_q[15:0], block_size: sz_q[16:0]};
        state_d = S_DONE;
        priority if (mprev_q && mnext_q) begin
          f_cmd     = '{op: OP_WRITE, pos: PosBits'(fi_q) - PosBits'(1)};
          f_wr_off  = prev_off_q;
          f_wr_size = prev_sz_q + sz_q + nsz_q;
          state_d   = S_F_FDEL;
        end else if (mprev_q) begin
          f_cmd     = '{op: OP_WRITE, pos: PosBits'(fi_q) - PosBits'(1)};
          f_wr_off  = prev_off_q;
          f_wr_size = prev_sz_q + sz_q;
        end else if (mnext_q) begin
          f_cmd     = '{op: OP_WRITE, pos: PosBits'(fi_q)};
          f_wr_off  = off_q;
          f_wr_size = nsz_q + sz_q;
        end else begin
          f_cmd     = '{op: OP_INSERT, pos: PosBits'(fi_q)};
          f_wr_off  = off_q;
          f_wr_size = sz_q;
          fcnt_d    = fcnt_q + FCW'(1);
        end
      end

      S_F_FDEL: begin
        f_cmd   = '{op: OP_DELETE, pos: PosBits'(fi_q)};
        fcnt_d  = fcnt_q - FCW'(1);
        state_d = S_DONE;
      end

      S_DONE: begin
        // hold until the output register is free
        if (!out_valid_d) begin
          out_d       = res_q;
          out_valid_d = 1'b1;
          state_d     = S_IDLE;
        end
      end

      default: state_d = S_IDLE;
    endcase

    // a pool size write reinitializes both tables
    if (cfg_we) begin
      f_cmd     = '{op: OP_WRITE, pos: '0};
      f_wr_off  = '0;
      f_wr_size = pool_w;
      fcnt_d    = (pool_w != '0) ? FCW'(1) : FCW'(0);
      ucnt_d    = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      fcnt_q      <= FCW'(1);
      ucnt_q      <= '0;
      fi_q        <= '0;
      ui_q        <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      fcnt_q      <= fcnt_d;
      ucnt_q      <= ucnt_d;
      fi_q        <= fi_d;
      ui_q        <= ui_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rsz_q       <= rsz_d;
    amask_q     <= amask_d;
    s_q         <= s_d;
    off_q       <= off_d;
    lead_q      <= lead_d;
    trail_q     <= trail_d;
    has_lead_q  <= has_lead_d;
    has_trail_q <= has_trail_d;
    sz_q        <= sz_d;
    prev_off_q  <= prev_off_d;
    prev_sz_q   <= prev_sz_d;
    nsz_q       <= nsz_d;
    mprev_q     <= mprev_d;
    mnext_q     <= mnext_d;
    res_q       <= res_d;
    out_q       <= out_d;
  end

  assign out_valid  = out_valid_q;
  assign out_data_o = out_q;

endmodule

[verif/tb_aligned_first_fit_allocator_top.sv]
// Self-checking testbench for the aligned first-fit pool allocator.
`timescale 1ns / 100ps

module tb_aligned_first_fit_allocator_top;
  import affa_pkg::*;

  localparam int MaxFree   = 16;
  localparam int MaxUsed   = 16;
  localparam int PoolLimit = 65536;
  localparam int StallCap  = 3000;

  // A queued request; with pick_used set, the offset to free is chosen from
  // the live used table at the moment the request is presented.
  typedef struct {
    req_t rq;
    bit   pick_used;
  } pend_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  req_t        in_data_i = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  rsp_t        out_data_o;
  logic        cfg_we = 1'b0;
  logic [16:0] cfg_wdata = '0;

  always #1 clk_i = ~clk_i;

  aligned_first_fit_allocator_top u_dut (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data_i (in_data_i),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data_o(out_data_o),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata)
  );

  // Shadow copy of the allocator tables.
  bit [16:0] pool_bytes;
  bit [15:0] free_offs[MaxFree];
  bit [16:0] free_lens[MaxFree];
  int        free_cnt;
  bit [15:0] used_offs[MaxUsed];
  bit [16:0] used_lens[MaxUsed];
  int        used_cnt;

  pend_t     pending_reqs[$];
  rsp_t      expected_rsps[$];
  int        errors = 0;
  int        n_ok = 0, n_nofit = 0, n_full = 0, n_notalloc = 0;
  bit        quiet = 1'b0;
  int        gap_left = 0;
  int        stall_left = 0;
  int        idle_cycles = 0;

  // Reinitialize the shadow tables for a new pool size (saturating).
  function automatic void set_pool(bit [16:0] v);
    pool_bytes = (v > PoolLimit) ? 17'(PoolLimit) : v;
    for (int i = 0; i < MaxFree; i++) begin
      free_offs[i] = '0;
      free_lens[i] = '0;
    end
    used_cnt = 0;
    if (pool_bytes == 0) begin
      free_cnt = 0;
    end else begin
      free_lens[0] = pool_bytes;
      free_cnt = 1;
    end
  endfunction

  function automatic rsp_t make_rsp(status_e st, int unsigned off, int unsigned sz);
    rsp_t r;
    r.status = st;
    r.offset = off[15:0];
    r.block_size = sz[16:0];
    return r;
  endfunction

  // Place a block by first aligned fit and return the response.
  function automatic rsp_t place_block(bit [16:0] req);
    int unsigned rsz, align, off, len, start, lead, trail;
    int pieces, pos;
    if (req >= 1 && req <= 8) begin
      rsz = (req == 1) ? 1 : (req == 2) ? 2 : (req <= 4) ? 4 : 8;
      align = rsz;
    end else begin
      rsz = (int'(req) + 15) & ~32'd15;
      if (rsz == 0) rsz = 16;
      align = 16;
    end
    for (int i = 0; i < free_cnt; i++) begin
      off = free_offs[i];
      len = free_lens[i];
      start = (off + align - 1) & ~(align - 1);
      if (start + rsz > off + len) continue;
      lead = start - off;
      trail = off + len - (start + rsz);
      pieces = (lead > 0) + (trail > 0);
      if (used_cnt >= MaxUsed || free_cnt - 1 + pieces > MaxFree)
        return make_rsp(STAT_FULL, 0, 0);
      if (pieces == 0) begin
        for (int k = i; k + 1 < free_cnt; k++) begin
          free_offs[k] = free_offs[k + 1];
          free_lens[k] = free_lens[k + 1];
        end
        free_cnt--;
      end else if (pieces == 1) begin
        if (lead > 0) begin
          free_lens[i] = lead[16:0];
        end else begin
          free_offs[i] = 16'(start + rsz);
          free_lens[i] = trail[16:0];
        end
      end else begin
        for (int k = free_cnt; k > i + 1; k--) begin
          free_offs[k] = free_offs[k - 1];
          free_lens[k] = free_lens[k - 1];
        end
        free_lens[i] = lead[16:0];
        free_offs[i + 1] = 16'(start + rsz);
        free_lens[i + 1] = trail[16:0];
        free_cnt++;
      end
      pos = 0;
      while (pos < used_cnt && used_offs[pos] < start) pos++;
      for (int k = used_cnt; k > pos; k--) begin
        used_offs[k] = used_offs[k - 1];
        used_lens[k] = used_lens[k - 1];
      end
      used_offs[pos] = start[15:0];
      used_lens[pos] = rsz[16:0];
      used_cnt++;
      return make_rsp(STAT_OK, start, rsz);
    end
    return make_rsp(STAT_NOFIT, 0, 0);
  endfunction

  // Return a used block to the free table, merging with neighbors.
  function automatic rsp_t release_block(bit [15:0] boff);
    int j, p;
    int unsigned off, len;
    bit mprev, mnext;
    j = 0;
    while (j < used_cnt && used_offs[j] != boff) j++;
    if (j >= used_cnt) return make_rsp(STAT_NOTALLOC, 0, 0);
    off = used_offs[j];
    len = used_lens[j];
    p = 0;
    while (p < free_cnt && free_offs[p] < off) p++;
    mprev = p > 0 && (int'(free_offs[p - 1]) + int'(free_lens[p - 1]) == off);
    mnext = p < free_cnt && (off + len == free_offs[p]);
    if (!mprev && !mnext && free_cnt >= MaxFree) return make_rsp(STAT_FULL, 0, 0);
    for (int k = j; k + 1 < used_cnt; k++) begin
      used_offs[k] = used_offs[k + 1];
      used_lens[k] = used_lens[k + 1];
    end
    used_cnt--;
    if (mprev && mnext) begin
      free_lens[p - 1] = 17'(free_lens[p - 1] + len + free_lens[p]);
      for (int k = p; k + 1 < free_cnt; k++) begin
        free_offs[k] = free_offs[k + 1];
        free_lens[k] = free_lens[k + 1];
      end
      free_cnt--;
    end else if (mprev) begin
      free_lens[p - 1] = 17'(free_lens[p - 1] + len);
    end else if (mnext) begin
      free_offs[p] = off[15:0];
      free_lens[p] = 17'(free_lens[p] + len);
    end else begin
      for (int k = free_cnt; k > p; k--) begin
        free_offs[k] = free_offs[k - 1];
        free_lens[k] = free_lens[k - 1];
      end
      free_offs[p] = off[15:0];
      free_lens[p] = len[16:0];
      free_cnt++;
    end
    return make_rsp(STAT_OK, off, len);
  endfunction

  function automatic void push_req(kind_e k, int unsigned sz, int unsigned off, bit pick);
    pend_t e;
    e.rq.kind = k;
    e.rq.req_bytes = sz[16:0];
    e.rq.block_offset = off[15:0];
    e.pick_used = pick;
    pending_reqs.push_back(e);
  endfunction

  // Mostly small sizes so the tables fill up; now and then any 17-bit value.
  function automatic int unsigned pick_size();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 55) return $urandom_range(0, 8);
    if (r < 90) return $urandom_range(9, 200);
    return $urandom_range(0, 17'h1FFFF);
  endfunction

  // Fill the request queue: mostly allocates and frees of live blocks,
  // the rest frees of random or small offsets.
  task automatic queue_random(int n);
    int unsigned r;
    for (int i = 0; i < n; i++) begin
      r = $urandom_range(0, 99);
      if (r < 50)
        push_req(KIND_ALLOC, pick_size(), $urandom_range(0, 16'hFFFF), 1'b0);
      else if (r < 85)
        push_req(KIND_FREE, $urandom_range(0, 17'h1FFFF), 0, 1'b1);
      else
        push_req(KIND_FREE, $urandom_range(0, 17'h1FFFF),
                 (r < 93) ? $urandom_range(0, 16'hFFFF) : $urandom_range(0, 64), 1'b0);
    end
  endtask

  // Hold until every request has its response, then let the block settle.
  task automatic drain();
    while (pending_reqs.size() != 0 || in_valid || expected_rsps.size() != 0)
      @(posedge clk_i);
    repeat (40) @(posedge clk_i);
  endtask

  task automatic write_pool(bit [16:0] v);
    @(posedge clk_i);
    cfg_we <= 1'b1;
    cfg_wdata <= v;
    set_pool(v);
    @(posedge clk_i);
    cfg_we <= 1'b0;
  endtask

  // Driver: predict on each accepted request, then present the next one
  // or idle for a burst.
  always @(posedge clk_i or negedge rst_ni) begin
    pend_t e;
    req_t  rq;
    if (!rst_ni) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall) begin
        if (in_data_i.kind == KIND_ALLOC)
          expected_rsps.push_back(place_block(in_data_i.req_bytes));
        else
          expected_rsps.push_back(release_block(in_data_i.block_offset));
      end
      if (!in_valid || !in_stall) begin
        if (gap_left > 0) begin
          gap_left <= gap_left - 1;
          in_valid <= 1'b0;
        end else if (pending_reqs.size() != 0) begin
          e = pending_reqs.pop_front();
          rq = e.rq;
          if (e.pick_used && used_cnt > 0)
            rq.block_offset = used_offs[$urandom_range(0, used_cnt - 1)];
          in_valid <= 1'b1;
          in_data_i <= rq;
          if (!quiet && $urandom_range(0, 3) == 0) gap_left <= $urandom_range(1, 16);
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Monitor: apply stall bursts and check each accepted response in order.
  always @(posedge clk_i) begin
    rsp_t exp_rsp;
    if (rst_ni) begin
      if (out_valid && !out_stall) begin
        if (expected_rsps.size() == 0) begin
          errors++;
          $display("%0t: unexpected response %p", $time, out_data_o);
        end else begin
          exp_rsp = expected_rsps.pop_front();
          if (out_data_o.status !== exp_rsp.status || out_data_o.offset !== exp_rsp.offset ||
              out_data_o.block_size !== exp_rsp.block_size) begin
            errors++;
            $display("%0t: mismatch expected %p actual %p", $time, exp_rsp, out_data_o);
          end
          case (status_e'(exp_rsp.status))
            STAT_OK:     n_ok++;
            STAT_NOFIT:  n_nofit++;
            STAT_FULL:   n_full++;
            default:     n_notalloc++;
          endcase
        end
      end
      if (stall_left > 0) begin
        out_stall <= 1'b1;
        stall_left <= stall_left - 1;
      end else begin
        out_stall <= 1'b0;
        if (!quiet && $urandom_range(0, 7) == 0) stall_left <= $urandom_range(1, 16);
      end
    end
  end

  // Watchdog: count cycles with work outstanding but no handshake.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((in_valid && !in_stall) || (out_valid && !out_stall) ||
          (pending_reqs.size() == 0 && !in_valid && expected_rsps.size() == 0)) begin
        idle_cycles <= 0;
      end else if (idle_cycles >= StallCap) begin
        $display("%0t: no progress for %0d cycles", $time, idle_cycles);
        $display("== FAIL ==");
        $finish;
      end else begin
        idle_cycles <= idle_cycles + 1;
      end
    end
  end

  initial begin
    bit [16:0] pools[7];
    pools = '{17'd4096, 17'd1, 17'd0, 17'd100, 17'h1FFFF, 17'd300, 17'd65536};
    set_pool(17'd65536);
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Directed: every rounding class, oversize and exact-fit cases, frees
    // of live, unknown and extreme offsets.
    for (int s = 0; s <= 9; s++) push_req(KIND_ALLOC, s, 16'hFFFF, 1'b0);
    push_req(KIND_ALLOC, 16, 0, 1'b0);
    push_req(KIND_ALLOC, 17, 0, 1'b0);
    push_req(KIND_ALLOC, 17'h1FFFF, 0, 1'b0);
    push_req(KIND_ALLOC, 65536, 0, 1'b0);
    push_req(KIND_FREE, 17'h1FFFF, 16'hFFFF, 1'b0);
    push_req(KIND_FREE, 0, 0, 1'b0);
    push_req(KIND_FREE, 0, 0, 1'b0);
    push_req(KIND_FREE, 0, 1, 1'b0);
    for (int i = 0; i < 5; i++) push_req(KIND_FREE, 0, 0, 1'b1);
    drain();
    write_pool(17'd65536);
    push_req(KIND_ALLOC, 65536, 0, 1'b0);
    push_req(KIND_FREE, 0, 0, 1'b0);

    // Random phases over several pool sizes; the last one runs without idling.
    foreach (pools[i]) begin
      drain();
      write_pool(pools[i]);
      quiet = (i == 6);
      queue_random(75);
    end
    drain();

    $display("Checked %0d responses: %0d ok, %0d no fit, %0d table full, %0d not allocated,",
             n_ok + n_nofit + n_full + n_notalloc, n_ok, n_nofit, n_full, n_notalloc);
    $display("over seven pool sizes from empty to saturated, with random idle and stall bursts.");
    if (errors == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

[aligned_first_fit_allocator_top.f]
src/affa_pkg.sv
src/affa_cell.sv
src/affa_chain.sv
src/aligned_first_fit_allocator_top.sv
verif/tb_aligned_first_fit_allocator_top.sv
